/* hdl/mcpt_pkg.sv */
package mcpt_pkg;

    // Build-time sizing
    localparam int CHANNELS      = 4;
    localparam int TIME_BITS     = 24;
    localparam int SLOTS         = 4;
    localparam int SLOT_BITS     = 2;
    localparam int FIELD_BITS    = 24;
    localparam int CHAN_FIELD_W  = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int MASK_BITS     = 4;
    localparam int CH_BITS       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef logic [TIME_BITS-1:0] time_t;

    // Per-channel status seen by the top level
    typedef struct packed {
        logic  on;
        time_t holdoff;
    } chan_stat_t;

    // Request kinds
    localparam logic KIND_TICK     = 1'b0;
    localparam logic KIND_ACTIVATE = 1'b1;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_INVALID = 2'd1;
    localparam logic [1:0] ERR_BUSY    = 2'd2;

    // Register reset values
    localparam time_t ON_TIME_RESET      = time_t'(1000);
    localparam time_t HOLDOFF_TIME_RESET = time_t'(5000);

    // Register field to internal time width (truncate or zero-extend)
    function automatic time_t to_time(input logic [FIELD_BITS-1:0] d);
        time_t r;
        r = '0;
        for (int i = 0; i < TIME_BITS; i++)
        begin
            if (i < FIELD_BITS)
                r[i] = d[i];
        end
        return r;
    endfunction

    // Internal time width to result field
    function automatic logic [FIELD_BITS-1:0] to_field(input time_t t);
        logic [FIELD_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < FIELD_BITS; i++)
        begin
            if (i < TIME_BITS)
                r[i] = t[i];
        end
        return r;
    endfunction

endpackage

/* hdl/mcpt_chan.sv */
module mcpt_chan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 tick,
    input  logic                 activate,
    input  mcpt_pkg::time_t      on_time,
    input  mcpt_pkg::time_t      holdoff_time,
    output mcpt_pkg::chan_stat_t cur,
    output mcpt_pkg::chan_stat_t nxt
);

    logic            on_reg;
    logic            on_next;
    mcpt_pkg::time_t elapsed_reg;
    mcpt_pkg::time_t elapsed_next;
    mcpt_pkg::time_t holdoff_reg;
    mcpt_pkg::time_t holdoff_next;
    mcpt_pkg::time_t elapsed_inc;
    logic            pulse_end;

    // Saturating on-time count
    assign elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign pulse_end   = on_reg && (elapsed_inc >= on_time);

    // Next state for one tick or one activate request
    always_comb
    begin
        on_next      = on_reg;
        elapsed_next = elapsed_reg;
        holdoff_next = holdoff_reg;
        if (tick)
        begin
            if (on_reg)
                elapsed_next = elapsed_inc;
            if (pulse_end)
            begin
                on_next      = 1'b0;
                holdoff_next = holdoff_time;
            end
            else if (holdoff_reg != '0)
            begin
                holdoff_next = holdoff_reg - 1'b1;
            end
        end
        else if (activate && !on_reg && (holdoff_reg == '0))
        begin
            on_next      = 1'b1;
            elapsed_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg      <= 1'b0;
            elapsed_reg <= '0;
            holdoff_reg <= '0;
        end
        else if (step)
        begin
            on_reg      <= on_next;
            elapsed_reg <= elapsed_next;
            holdoff_reg <= holdoff_next;
        end
    end

    assign cur.on      = on_reg;
    assign cur.holdoff = holdoff_reg;
    assign nxt.on      = on_next;
    assign nxt.holdoff = holdoff_next;

endmodule

/* hdl/multi_channel_pulse_timer_with_holdoff.sv */
// Channel   | handshake            | payload
// ----------+----------------------+-----------------------------------------------
// input     | in_valid / in_ready  | kind, channel
// result    | out_valid/ out_ready | accepted, error_code, on_mask, addressed_on,
//           |                      | addressed_available, addressed_holdoff_left
// config    | cfg_we               | cfg_index, cfg_data
//
// One request per cycle while results are taken; a taken request sits in the input
// register, then its result loads into the result register once that register is free
// or being read. All channels update together in the single logic step between those
// registers.
// Reset puts every channel off with no holdoff and loads the register defaults.
// A stalled result holds the pipe; in_ready falls only when both stages are full.
module multi_channel_pulse_timer_with_holdoff (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    kind,
    input  logic [mcpt_pkg::CHAN_FIELD_W-1:0]       channel,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic                                    accepted,
    output logic [1:0]                              error_code,
    output logic [mcpt_pkg::MASK_BITS-1:0]          on_mask,
    output logic                                    addressed_on,
    output logic                                    addressed_available,
    output logic [mcpt_pkg::FIELD_BITS-1:0]         addressed_holdoff_left,
    input  logic                                    cfg_we,
    input  logic [mcpt_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [mcpt_pkg::FIELD_BITS-1:0]         cfg_data
);

    mcpt_pkg::time_t      on_time_reg [mcpt_pkg::SLOTS];
    mcpt_pkg::time_t      holdoff_time_reg [mcpt_pkg::SLOTS];
    mcpt_pkg::chan_stat_t stat_cur [mcpt_pkg::CHANNELS];
    mcpt_pkg::chan_stat_t stat_nxt [mcpt_pkg::CHANNELS];

    logic                              s1_valid_reg;
    logic                              s1_kind_reg;
    logic [mcpt_pkg::CHAN_FIELD_W-1:0] s1_channel_reg;
    logic                              advance;
    logic                              is_tick;
    logic                              ch_valid;
    logic [mcpt_pkg::CH_BITS-1:0]      ch_idx;
    logic                              ch_busy;

    logic                              out_valid_reg;
    logic                              accepted_next;
    logic                              accepted_reg;
    logic [1:0]                        error_next;
    logic [1:0]                        error_reg;
    logic [mcpt_pkg::MASK_BITS-1:0]    mask_next;
    logic [mcpt_pkg::MASK_BITS-1:0]    mask_reg;
    logic                              a_on_next;
    logic                              a_on_reg;
    logic                              a_av_next;
    logic                              a_av_reg;
    mcpt_pkg::time_t                   a_hl_next;
    mcpt_pkg::time_t                   a_hl_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mcpt_pkg::SLOTS; i++)
            begin
                on_time_reg[i]      <= mcpt_pkg::ON_TIME_RESET;
                holdoff_time_reg[i] <= mcpt_pkg::HOLDOFF_TIME_RESET;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index < mcpt_pkg::CFG_IDX_BITS'(mcpt_pkg::SLOTS))
                on_time_reg[cfg_index[mcpt_pkg::SLOT_BITS-1:0]] <= mcpt_pkg::to_time(cfg_data);
            else
                holdoff_time_reg[cfg_index[mcpt_pkg::SLOT_BITS-1:0]] <=
                    mcpt_pkg::to_time(cfg_data);
        end
    end

    // Pipeline flow
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_kind_reg    <= kind;
            s1_channel_reg <= channel;
        end
    end

    // Request decode
    assign is_tick  = (s1_kind_reg == mcpt_pkg::KIND_TICK);
    assign ch_valid = (s1_channel_reg < mcpt_pkg::CHAN_FIELD_W'(mcpt_pkg::CHANNELS));
    assign ch_idx   = s1_channel_reg[mcpt_pkg::CH_BITS-1:0];
    assign ch_busy  = ch_valid && (stat_cur[ch_idx].on || (stat_cur[ch_idx].holdoff != '0));

    // Channel timers
    for (genvar c = 0; c < mcpt_pkg::CHANNELS; c++)
    begin : g_chan
        mcpt_chan u_chan (
            .clk          (clk),
            .rst_n        (rst_n),
            .step         (advance),
            .tick         (is_tick),
            .activate     (!is_tick && ch_valid && (ch_idx == mcpt_pkg::CH_BITS'(c))),
            .on_time      (on_time_reg[c]),
            .holdoff_time (holdoff_time_reg[c]),
            .cur          (stat_cur[c]),
            .nxt          (stat_nxt[c])
        );
    end

    // Result from the state after the request
    always_comb
    begin
        accepted_next = 1'b0;
        error_next    = mcpt_pkg::ERR_NONE;
        if (!is_tick)
        begin
            if (!ch_valid)
                error_next = mcpt_pkg::ERR_INVALID;
            else if (ch_busy)
                error_next = mcpt_pkg::ERR_BUSY;
            else
                accepted_next = 1'b1;
        end

        mask_next = '0;
        for (int c = 0; c < mcpt_pkg::CHANNELS; c++)
            mask_next[c] = stat_nxt[c].on;

        a_on_next = 1'b0;
        a_av_next = 1'b0;
        a_hl_next = '0;
        if (ch_valid)
        begin
            a_on_next = stat_nxt[ch_idx].on;
            a_av_next = !stat_nxt[ch_idx].on && (stat_nxt[ch_idx].holdoff == '0);
            a_hl_next = stat_nxt[ch_idx].holdoff;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            accepted_reg <= accepted_next;
            error_reg    <= error_next;
            mask_reg     <= mask_next;
            a_on_reg     <= a_on_next;
            a_av_reg     <= a_av_next;
            a_hl_reg     <= a_hl_next;
        end
    end

    assign out_valid              = out_valid_reg;
    assign accepted               = accepted_reg;
    assign error_code             = error_reg;
    assign on_mask                = mask_reg;
    assign addressed_on           = a_on_reg;
    assign addressed_available    = a_av_reg;
    assign addressed_holdoff_left = mcpt_pkg::to_field(a_hl_reg);

endmodule

/* hdl/mcpt_checker.sv */
module mcpt_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic                                accepted,
    input logic [1:0]                          error_code,
    input logic [mcpt_pkg::MASK_BITS-1:0]      on_mask,
    input logic                                addressed_on,
    input logic                                addressed_available,
    input logic [mcpt_pkg::FIELD_BITS-1:0]     addressed_holdoff_left
);

    // A started pulse carries no error and shows its channel on
    a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |-> (error_code == mcpt_pkg::ERR_NONE) && addressed_on
            && (on_mask != '0))
        else $error("accepted request with error or channel off");

    // Available means off with no holdoff left
    a_avail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && addressed_available) |-> !addressed_on && (addressed_holdoff_left == '0))
        else $error("available channel is on or in holdoff");

    // Invalid channel reports an empty status
    a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (error_code == mcpt_pkg::ERR_INVALID)) |->
            !addressed_on && !addressed_available && (addressed_holdoff_left == '0))
        else $error("invalid channel has status");

    // Only defined error codes
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (error_code == mcpt_pkg::ERR_NONE) || (error_code == mcpt_pkg::ERR_INVALID)
            || (error_code == mcpt_pkg::ERR_BUSY))
        else $error("undefined error code");

    // A stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(error_code) && $stable(on_mask))
        else $error("stalled result dropped or changed");

endmodule

bind multi_channel_pulse_timer_with_holdoff mcpt_checker u_mcpt_checker (.*);

/* test/pulse_timer_checker.sv */
`timescale 1ns / 1ps

module pulse_timer_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              kind,
    input  logic [mcpt_pkg::CHAN_FIELD_W-1:0] channel,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic                              accepted,
    input  logic [1:0]                        error_code,
    input  logic [mcpt_pkg::MASK_BITS-1:0]    on_mask,
    input  logic                              addressed_on,
    input  logic                              addressed_available,
    input  logic [mcpt_pkg::FIELD_BITS-1:0]   addressed_holdoff_left,
    input  logic                              cfg_we,
    input  logic [mcpt_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [mcpt_pkg::FIELD_BITS-1:0]   cfg_data,
    output int                                fail_count,
    output int                                pending
);

    // Holdoff registers follow the on-time registers
    localparam int HOLDOFF_REG = mcpt_pkg::SLOTS;
    localparam int PRINT_CAP   = 100;

    typedef struct packed {
        logic                            accepted;
        logic [1:0]                      err;
        logic [mcpt_pkg::MASK_BITS-1:0]  on_mask;
        logic                            a_on;
        logic                            a_avail;
        logic [mcpt_pkg::FIELD_BITS-1:0] a_left;
    } timer_status_t;

    // Own copy of the timer state and its settings
    logic            out_on      [mcpt_pkg::SLOTS];
    mcpt_pkg::time_t elapsed     [mcpt_pkg::SLOTS];
    mcpt_pkg::time_t lockout     [mcpt_pkg::SLOTS];
    mcpt_pkg::time_t pulse_len   [mcpt_pkg::SLOTS];
    mcpt_pkg::time_t lockout_len [mcpt_pkg::SLOTS];

    timer_status_t expected_status [$];
    timer_status_t want;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // Apply one request to the copied state and return the status it should report
    function automatic timer_status_t advance_timers(input logic k,
                                                     input logic [mcpt_pkg::CHAN_FIELD_W-1:0] ch);
        timer_status_t r;
        logic          addr_ok;
        int            sel;
        r       = '0;
        addr_ok = (ch < mcpt_pkg::CHANNELS);
        sel     = ch;
        if (k == mcpt_pkg::KIND_TICK)
        begin
            for (int c = 0; c < mcpt_pkg::CHANNELS; c++)
            begin
                if (out_on[c])
                begin
                    if (elapsed[c] != '1)
                        elapsed[c] = elapsed[c] + 1'b1;
                    // pulse over: holdoff loads, no countdown on this tick
                    if (elapsed[c] >= pulse_len[c])
                    begin
                        out_on[c]  = 1'b0;
                        lockout[c] = lockout_len[c];
                        continue;
                    end
                end
                if (lockout[c] != '0)
                    lockout[c] = lockout[c] - 1'b1;
            end
        end
        else if (!addr_ok)
            r.err = mcpt_pkg::ERR_INVALID;
        else if (out_on[sel] || lockout[sel] != '0)
            r.err = mcpt_pkg::ERR_BUSY;
        else
        begin
            out_on[sel]  = 1'b1;
            elapsed[sel] = '0;
            r.accepted   = 1'b1;
        end
        for (int c = 0; c < mcpt_pkg::CHANNELS; c++)
            r.on_mask[c] = out_on[c];
        if (addr_ok)
        begin
            r.a_on    = out_on[sel];
            r.a_avail = !out_on[sel] && lockout[sel] == '0;
            r.a_left  = lockout[sel];
        end
        return r;
    endfunction

    task automatic report_fault(input string msg);
        if (fail_count < PRINT_CAP)
            $display("%0t ns: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [mcpt_pkg::FIELD_BITS-1:0] got,
                               input logic [mcpt_pkg::FIELD_BITS-1:0] exp_val);
        if (got !== exp_val)
            report_fault($sformatf("%s: got %0h, expected %0h", name, got, exp_val));
    endtask

    // Watch the ports: settings, results against the oldest expectation, new requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < mcpt_pkg::SLOTS; c++)
            begin
                out_on[c]      = 1'b0;
                elapsed[c]     = '0;
                lockout[c]     = '0;
                pulse_len[c]   = mcpt_pkg::ON_TIME_RESET;
                lockout_len[c] = mcpt_pkg::HOLDOFF_TIME_RESET;
            end
            expected_status.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index < HOLDOFF_REG)
                    pulse_len[cfg_index[mcpt_pkg::SLOT_BITS-1:0]] =
                        mcpt_pkg::time_t'(cfg_data);
                else
                    lockout_len[cfg_index[mcpt_pkg::SLOT_BITS-1:0]] =
                        mcpt_pkg::time_t'(cfg_data);
            end
            if (out_valid && out_ready)
            begin
                if (expected_status.size() == 0)
                    report_fault("result with no request outstanding");
                else
                begin
                    want = expected_status.pop_front();
                    check_field("accepted", accepted, want.accepted);
                    check_field("error_code", error_code, want.err);
                    check_field("on_mask", on_mask, want.on_mask);
                    check_field("addressed_on", addressed_on, want.a_on);
                    check_field("addressed_available", addressed_available, want.a_avail);
                    check_field("addressed_holdoff_left", addressed_holdoff_left,
                                want.a_left);
                end
            end
            if (in_valid && in_ready)
                expected_status.push_back(advance_timers(kind, channel));
            pending = expected_status.size();
        end
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int ON_TIME_REG     = 0;
    localparam int HOLDOFF_REG     = mcpt_pkg::SLOTS;
    localparam int PHASES          = 5;
    localparam int PHASE_REQUESTS  = 140;
    localparam int SETTLE_CYCLES   = 4;
    localparam int CYCLE_LIMIT     = 300000;
    localparam mcpt_pkg::time_t TIME_MAX = '1;

    typedef logic [mcpt_pkg::CHAN_FIELD_W-1:0] chan_sel_t;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              in_valid  = 1'b0;
    logic                              in_ready;
    logic                              kind      = mcpt_pkg::KIND_TICK;
    chan_sel_t                         channel   = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic                              accepted;
    logic [1:0]                        error_code;
    logic [mcpt_pkg::MASK_BITS-1:0]    on_mask;
    logic                              addressed_on;
    logic                              addressed_available;
    logic [mcpt_pkg::FIELD_BITS-1:0]   addressed_holdoff_left;
    logic                              cfg_we    = 1'b0;
    logic [mcpt_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [mcpt_pkg::FIELD_BITS-1:0]   cfg_data  = '0;

    int              fail_count;
    int              pending;
    int              cycle_count = 0;
    int              gap_pct     = 0;
    int              stall_pct   = 0;
    mcpt_pkg::time_t pulse_cfg   [mcpt_pkg::SLOTS];
    mcpt_pkg::time_t lockout_cfg [mcpt_pkg::SLOTS];

    multi_channel_pulse_timer_with_holdoff i_dut (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .in_valid               (in_valid),
        .in_ready               (in_ready),
        .kind                   (kind),
        .channel                (channel),
        .out_valid              (out_valid),
        .out_ready              (out_ready),
        .accepted               (accepted),
        .error_code             (error_code),
        .on_mask                (on_mask),
        .addressed_on           (addressed_on),
        .addressed_available    (addressed_available),
        .addressed_holdoff_left (addressed_holdoff_left),
        .cfg_we                 (cfg_we),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data)
    );

    pulse_timer_checker i_checker (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .in_valid               (in_valid),
        .in_ready               (in_ready),
        .kind                   (kind),
        .channel                (channel),
        .out_valid              (out_valid),
        .out_ready              (out_ready),
        .accepted               (accepted),
        .error_code             (error_code),
        .on_mask                (on_mask),
        .addressed_on           (addressed_on),
        .addressed_available    (addressed_available),
        .addressed_holdoff_left (addressed_holdoff_left),
        .cfg_we                 (cfg_we),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data),
        .fail_count             (fail_count),
        .pending                (pending)
    );

    always #10 clk = ~clk;

    // Result side back-pressure
    always @(posedge clk)
    begin
        if (stall_pct == 0)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one request, hold it until taken, then maybe leave a gap
    task automatic send_request(input logic k, input chan_sel_t ch);
        in_valid <= 1'b1;
        kind     <= k;
        channel  <= ch;
        do
            @(posedge clk);
        while (!in_ready);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < gap_pct);
        end
    endtask

    // Stop sending and let every outstanding result come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all eight timing registers from pulse_cfg / lockout_cfg
    task automatic load_timers();
        for (int c = 0; c < mcpt_pkg::SLOTS; c++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= mcpt_pkg::CFG_IDX_BITS'(ON_TIME_REG + c);
            cfg_data  <= pulse_cfg[c];
            @(posedge clk);
        end
        for (int c = 0; c < mcpt_pkg::SLOTS; c++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= mcpt_pkg::CFG_IDX_BITS'(HOLDOFF_REG + c);
            cfg_data  <= lockout_cfg[c];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int roll;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset timings: start, busy, invalid request, invalid status
        send_request(mcpt_pkg::KIND_ACTIVATE, 3'd0);
        send_request(mcpt_pkg::KIND_ACTIVATE, 3'd0);
        send_request(mcpt_pkg::KIND_ACTIVATE, 3'd7);
        send_request(mcpt_pkg::KIND_TICK, 3'd4);
        send_request(mcpt_pkg::KIND_TICK, 3'd0);
        send_request(mcpt_pkg::KIND_ACTIVATE, 3'd3);
        wait_drained();

        // Shorten pulses while channels 0 and 3 are running
        pulse_cfg   = '{0, 1, 2, 5};
        lockout_cfg = '{0, 1, 3, 2};
        load_timers();

        // Zero on-time, zero holdoff, holdoff lockout, invalid channels
        send_request(mcpt_pkg::KIND_TICK, 3'd0);
        send_request(mcpt_pkg::KIND_ACTIVATE, 3'd0);
        send_request(mcpt_pkg::KIND_TICK, 3'd0);
        send_request(mcpt_pkg::KIND_ACTIVATE, 3'd1);
        send_request(mcpt_pkg::KIND_TICK, 3'd1);
        send_request(mcpt_pkg::KIND_ACTIVATE, 3'd1);
        send_request(mcpt_pkg::KIND_TICK, 3'd1);
        send_request(mcpt_pkg::KIND_ACTIVATE, 3'd1);
        send_request(mcpt_pkg::KIND_ACTIVATE, 3'd2);
        send_request(mcpt_pkg::KIND_TICK, 3'd2);
        send_request(mcpt_pkg::KIND_TICK, 3'd2);
        send_request(mcpt_pkg::KIND_TICK, 3'd3);
        send_request(mcpt_pkg::KIND_ACTIVATE, 3'd3);
        send_request(mcpt_pkg::KIND_ACTIVATE, 3'd4);
        send_request(mcpt_pkg::KIND_ACTIVATE, 3'd5);
        send_request(mcpt_pkg::KIND_ACTIVATE, 3'd6);
        send_request(mcpt_pkg::KIND_TICK, 3'd6);
        send_request(mcpt_pkg::KIND_TICK, 3'd7);
        send_request(mcpt_pkg::KIND_TICK, 3'd5);
        wait_drained();

        // Random phases, each with its own timings and idling
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                1:       begin gap_pct = 66; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 66; end
                3:       begin gap_pct = 15; stall_pct = 15; end
                default: begin gap_pct = 0;  stall_pct = 0;  end
            endcase
            // last phase: extreme values, some channels lock up for good
            if (p == PHASES - 1)
            begin
                pulse_cfg   = '{TIME_MAX, 1, 0, 2};
                lockout_cfg = '{3, TIME_MAX, 0, TIME_MAX};
            end
            else
            begin
                for (int c = 0; c < mcpt_pkg::SLOTS; c++)
                begin
                    pulse_cfg[c]   = mcpt_pkg::time_t'($urandom_range(0, 6));
                    lockout_cfg[c] = mcpt_pkg::time_t'($urandom_range(0, 8));
                end
            end
            load_timers();

            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                    send_request(mcpt_pkg::KIND_TICK,
                                 (roll % 5 == 0) ? chan_sel_t'($urandom_range(0, 7))
                                 : chan_sel_t'($urandom_range(0, mcpt_pkg::CHANNELS - 1)));
                else if (roll < 90)
                    send_request(mcpt_pkg::KIND_ACTIVATE,
                                 chan_sel_t'($urandom_range(0, mcpt_pkg::CHANNELS - 1)));
                else
                    send_request(mcpt_pkg::KIND_ACTIVATE, chan_sel_t'($urandom_range(0, 7)));
                // now and then hold off until the pipe is empty
                if ($urandom_range(0, 39) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
